FILE: src/sfr_pkg.sv
package sfr_pkg;

    localparam int MAX_PATTERN = 8;
    localparam int IDX_W       = $clog2(MAX_PATTERN);
    localparam int CNT_W       = $clog2(MAX_PATTERN + 1);
    localparam int CFG_IDX_W   = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SEARCH_PATTERN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEARCH_LENGTH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACE_PATTERN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACE_LENGTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACE_MODE    = 3'd4;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       string_end;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       run_last;
        logic       output_end;
    } out_item_t;

    // per-cell control from the window control logic
    typedef struct packed {
        logic take;
        logic shift;
        logic tail;
        logic care;
    } cell_ctl_t;

    // results caused by one request, handed to the output serializer
    typedef struct packed {
        logic [MAX_PATTERN-1:0][7:0] bytes;
        logic [CNT_W-1:0]            num;
        logic                        has;
        logic                        last;
    } burst_t;

endpackage

FILE: src/sfr_cell.sv
module sfr_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  sfr_pkg::cell_ctl_t ctl,
    input  logic [7:0]        in_byte,
    input  logic [7:0]        pat_byte,
    input  logic [7:0]        nbr_byte,
    output logic [7:0]        cur_byte,
    output logic              hit
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    // the tail cell sees the incoming byte as if already appended
    assign cur_byte = ctl.tail ? in_byte : byte_reg;
    assign hit      = !ctl.care || (cur_byte == pat_byte);

    always_comb
    begin
        byte_next = byte_reg;
        if (ctl.take)
        begin
            byte_next = ctl.shift ? nbr_byte : cur_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= '0;
        end
        else
        begin
            byte_reg <= byte_next;
        end
    end

endmodule

FILE: src/sfr_emit.sv
module sfr_emit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  sfr_pkg::burst_t     burst,
    output logic                can_load,
    output logic                dst_valid,
    input  logic                dst_ready,
    output sfr_pkg::out_item_t  dst_data
);

    logic                                        busy_reg, busy_next;
    logic [sfr_pkg::IDX_W-1:0]                   idx_reg, idx_next;
    logic [sfr_pkg::CNT_W-1:0]                   num_reg, num_next;
    logic                                        has_reg, has_next;
    logic                                        end_reg, end_next;
    logic [sfr_pkg::MAX_PATTERN-1:0][7:0]        bytes_reg, bytes_next;
    logic                                        last_beat;

    assign last_beat = ({1'b0, idx_reg} + sfr_pkg::CNT_W'(1)) == num_reg;
    assign can_load  = !busy_reg || (dst_ready && last_beat);

    assign dst_valid           = busy_reg;
    assign dst_data.out_byte   = has_reg ? bytes_reg[idx_reg] : 8'h00;
    assign dst_data.has_byte   = has_reg;
    assign dst_data.run_last   = last_beat;
    assign dst_data.output_end = end_reg && last_beat;

    always_comb
    begin
        busy_next  = busy_reg;
        idx_next   = idx_reg;
        num_next   = num_reg;
        has_next   = has_reg;
        end_next   = end_reg;
        bytes_next = bytes_reg;
        if (load)
        begin
            busy_next  = 1'b1;
            idx_next   = '0;
            num_next   = burst.num;
            has_next   = burst.has;
            end_next   = burst.last;
            bytes_next = burst.bytes;
        end
        else if (busy_reg && dst_ready)
        begin
            if (last_beat)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + sfr_pkg::IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
            num_reg  <= '0;
            has_reg  <= 1'b0;
            end_reg  <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
            num_reg  <= num_next;
            has_reg  <= has_next;
            end_reg  <= end_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bytes_reg <= bytes_next;
    end

endmodule

FILE: src/stream_find_replace.sv
// Streaming find-and-replace over byte strings.
// src: one byte per request, string_end set on the final byte of a string.
// dst: one output byte per transfer; run_last marks the last result of an
//   input request, output_end the last result of a string. A string whose
//   output is empty yields one marker result with has_byte low.
// cfg: register writes (index, data), always ready; write only while idle.
//   Writing the search length drops any pending bytes.
// Pending bytes live in a row of MAX_PATTERN cells; each cell holds one byte,
// compares it with its pattern byte and passes it to its left neighbor when
// the oldest byte is released.
// The first result of a request is registered and shown in the cycle after accept.
// Throughput: one request per cycle while each yields at most one result.
// A request that yields k results holds the output serializer while they are
// sent, and src_ready stays low until the last of them is taken. If the receiver
// stalls, the current result holds and src_ready stays low while it waits.
// Reset clears the pending window, the output serializer and the registers
// (search length 1, everything else zero).
module stream_find_replace (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              src_valid,
    output logic                              src_ready,
    input  sfr_pkg::in_item_t                 src_data,
    output logic                              dst_valid,
    input  logic                              dst_ready,
    output sfr_pkg::out_item_t                dst_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sfr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [63:0]                       cfg_data
);

    localparam int N = sfr_pkg::MAX_PATTERN;

    logic [63:0]                 search_pattern_reg, search_pattern_next;
    logic [sfr_pkg::CNT_W-1:0]   search_length_reg, search_length_next;
    logic [63:0]                 replace_pattern_reg, replace_pattern_next;
    logic [sfr_pkg::CNT_W-1:0]   replace_length_reg, replace_length_next;
    logic                        replace_mode_reg, replace_mode_next;
    logic [sfr_pkg::IDX_W-1:0]   count_reg, count_next;

    logic [sfr_pkg::CNT_W-1:0]   slen, rlen, cnt_a;
    logic                        accept, cfg_wr, last, full, match, do_replace;
    logic [N-1:0][7:0]           win_bytes, nbr_bytes, pat_bytes;
    logic [N-1:0]                hits;
    sfr_pkg::cell_ctl_t [N-1:0]  ctl;
    sfr_pkg::burst_t             burst;
    logic                        can_load;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign src_ready = can_load;
    assign accept    = src_valid && src_ready;
    assign last      = src_data.string_end;

    always_comb
    begin
        if (search_length_reg == '0)
            slen = sfr_pkg::CNT_W'(1);
        else if (search_length_reg > sfr_pkg::CNT_W'(N))
            slen = sfr_pkg::CNT_W'(N);
        else
            slen = search_length_reg;
        if (replace_length_reg > sfr_pkg::CNT_W'(N))
            rlen = sfr_pkg::CNT_W'(N);
        else
            rlen = replace_length_reg;
    end

    assign cnt_a      = {1'b0, count_reg} + sfr_pkg::CNT_W'(1);
    assign full       = cnt_a >= slen;
    assign match      = full && (&hits);
    assign do_replace = match && (!replace_mode_reg || last);
    assign pat_bytes  = search_pattern_reg;

    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            ctl[i].take  = accept;
            ctl[i].shift = full && !match && !last;
            ctl[i].tail  = count_reg == sfr_pkg::IDX_W'(i);
            ctl[i].care  = sfr_pkg::CNT_W'(i) < slen;
        end
        for (int i = 0; i < N - 1; i++)
        begin
            nbr_bytes[i] = win_bytes[i + 1];
        end
        nbr_bytes[N-1] = 8'h00;
    end

    for (genvar g = 0; g < N; g++)
    begin : g_cell
        sfr_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl[g]),
            .in_byte  (src_data.in_byte),
            .pat_byte (pat_bytes[g]),
            .nbr_byte (nbr_bytes[g]),
            .cur_byte (win_bytes[g]),
            .hit      (hits[g])
        );
    end

    // results of this request: replacement, a prefix of the window, or an end marker
    always_comb
    begin
        burst.last = last;
        burst.has  = 1'b1;
        if (do_replace)
        begin
            burst.bytes = replace_pattern_reg;
            burst.num   = rlen;
        end
        else
        begin
            burst.bytes = win_bytes;
            if (last || match)
                burst.num = cnt_a;
            else if (full)
                burst.num = sfr_pkg::CNT_W'(1);
            else
                burst.num = '0;
        end
        if (last && burst.num == '0)
        begin
            burst.num = sfr_pkg::CNT_W'(1);
            burst.has = 1'b0;
        end
    end

    sfr_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept && burst.num != '0),
        .burst     (burst),
        .can_load  (can_load),
        .dst_valid (dst_valid),
        .dst_ready (dst_ready),
        .dst_data  (dst_data)
    );

    always_comb
    begin
        search_pattern_next  = search_pattern_reg;
        search_length_next   = search_length_reg;
        replace_pattern_next = replace_pattern_reg;
        replace_length_next  = replace_length_reg;
        replace_mode_next    = replace_mode_reg;
        count_next           = count_reg;
        if (accept)
        begin
            if (last || match)
                count_next = '0;
            else if (!full)
                count_next = count_reg + sfr_pkg::IDX_W'(1);
        end
        if (cfg_wr)
        begin
            case (cfg_index)
                sfr_pkg::REG_SEARCH_PATTERN:  search_pattern_next = cfg_data;
                sfr_pkg::REG_SEARCH_LENGTH:
                begin
                    search_length_next = cfg_data[sfr_pkg::CNT_W-1:0];
                    count_next         = '0;
                end
                sfr_pkg::REG_REPLACE_PATTERN: replace_pattern_next = cfg_data;
                sfr_pkg::REG_REPLACE_LENGTH:  replace_length_next = cfg_data[sfr_pkg::CNT_W-1:0];
                sfr_pkg::REG_REPLACE_MODE:    replace_mode_next = cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            search_pattern_reg  <= '0;
            search_length_reg   <= sfr_pkg::CNT_W'(1);
            replace_pattern_reg <= '0;
            replace_length_reg  <= '0;
            replace_mode_reg    <= 1'b0;
            count_reg           <= '0;
        end
        else
        begin
            search_pattern_reg  <= search_pattern_next;
            search_length_reg   <= search_length_next;
            replace_pattern_reg <= replace_pattern_next;
            replace_length_reg  <= replace_length_next;
            replace_mode_reg    <= replace_mode_next;
            count_reg           <= count_next;
        end
    end

    // pending bytes never reach a full pattern between requests
    a_count_below_len: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, count_reg} < slen)
        else $error("pending count not below search length");

    // the end of a string always produces at least one result
    a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last |=> dst_valid)
        else $error("no result after string end");

    // the window is empty after the final byte of a string
    a_end_clears_window: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last |=> count_reg == '0)
        else $error("window not flushed at string end");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 4;
    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES   = 80;
    localparam int RANDOM_ITEMS  = 320;
    localparam int PHASE_ITEMS   = 30;
    localparam int CYCLE_LIMIT   = 200000;

    // indexes past the end of the register list; writes there are dropped
    localparam logic [sfr_pkg::CFG_IDX_W-1:0] REG_FIRST_UNUSED = 3'd5;
    localparam logic [sfr_pkg::CFG_IDX_W-1:0] REG_LAST_UNUSED  = 3'd7;

    typedef enum logic { ROW_WRITE, ROW_ITEM } row_kind_t;

    typedef struct {
        row_kind_t                      kind;
        logic [sfr_pkg::CFG_IDX_W-1:0]  idx;
        logic [63:0]                    val;
        sfr_pkg::in_item_t              item;
        bit                             typed;
        sfr_pkg::out_item_t             want;
    } dir_row_t;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           src_valid = 1'b0;
    logic                           src_ready;
    sfr_pkg::in_item_t              src_data  = '0;
    logic                           dst_valid;
    logic                           dst_ready = 1'b0;
    sfr_pkg::out_item_t             dst_data;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [sfr_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [63:0]                    cfg_data  = '0;

    // shadow registers and window of the predictor
    logic [63:0]    find_pat   = '0;
    logic [3:0]     find_len   = 4'd1;
    logic [63:0]    subst_pat  = '0;
    logic [3:0]     subst_len  = '0;
    logic           subst_mode = 1'b0;
    logic [7:0]     win [sfr_pkg::MAX_PATTERN];
    int             win_cnt    = 0;

    sfr_pkg::out_item_t predicted_out [$];
    dir_row_t           dir_rows [$];

    bit             src_gap_en    = 1'b1;
    bit             sink_stall_en = 1'b1;
    int             hold_asked    = 0;
    int             hold_served   = 0;

    int             cycle_count = 0;
    int             n_requests  = 0;
    int             n_directed  = 0;
    int             n_results   = 0;
    int             n_writes    = 0;
    int             n_setups    = 0;
    int             n_errors    = 0;

    stream_find_replace DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_ready (src_ready),
        .src_data  (src_data),
        .dst_valid (dst_valid),
        .dst_ready (dst_ready),
        .dst_data  (dst_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout at cycle %0d, %0d results outstanding",
                     cycle_count, predicted_out.size());
            $display("status: fail");
            $finish;
        end
    end

    function automatic sfr_pkg::out_item_t result_of(logic [7:0] b, logic has, logic last,
                                                     logic oend);
        sfr_pkg::out_item_t r;
        r.out_byte   = b;
        r.has_byte   = has;
        r.run_last   = last;
        r.output_end = oend;
        return r;
    endfunction

    function automatic sfr_pkg::in_item_t make_item(logic [7:0] b, logic e);
        sfr_pkg::in_item_t it;
        it.in_byte    = b;
        it.string_end = e;
        return it;
    endfunction

    function automatic int eff_find_len();
        if (find_len == 0)
            return 1;
        if (find_len > sfr_pkg::MAX_PATTERN)
            return sfr_pkg::MAX_PATTERN;
        return find_len;
    endfunction

    // one step of the find/replace window
    task automatic find_replace_step(input sfr_pkg::in_item_t it, input bit keep);
        sfr_pkg::out_item_t burst [$];
        int                 slen;
        int                 rlen;
        bit                 hit;
        slen = eff_find_len();
        rlen = (subst_len > sfr_pkg::MAX_PATTERN) ? sfr_pkg::MAX_PATTERN : subst_len;
        if (win_cnt < sfr_pkg::MAX_PATTERN)
        begin
            win[win_cnt] = it.in_byte;
            win_cnt++;
        end
        if (win_cnt >= slen)
        begin
            hit = 1'b1;
            for (int i = 0; i < slen; i++)
                if (win[i] != find_pat[8*i +: 8])
                    hit = 1'b0;
            if (hit)
            begin
                if (!subst_mode || it.string_end)
                    for (int i = 0; i < rlen; i++)
                        burst.push_back(result_of(subst_pat[8*i +: 8], 1'b1, 1'b0, 1'b0));
                else
                    for (int i = 0; i < slen; i++)
                        burst.push_back(result_of(win[i], 1'b1, 1'b0, 1'b0));
                win_cnt = 0;
            end
            else
            begin
                burst.push_back(result_of(win[0], 1'b1, 1'b0, 1'b0));
                for (int i = 1; i < sfr_pkg::MAX_PATTERN; i++)
                    win[i-1] = win[i];
                win_cnt--;
            end
        end
        if (it.string_end)
        begin
            for (int i = 0; i < win_cnt && burst.size() < sfr_pkg::MAX_PATTERN; i++)
                burst.push_back(result_of(win[i], 1'b1, 1'b0, 1'b0));
            win_cnt = 0;
            // nothing left to say: a bare end marker
            if (burst.size() == 0)
                burst.push_back(result_of(8'h00, 1'b0, 1'b0, 1'b0));
            burst[burst.size()-1].output_end = 1'b1;
        end
        if (burst.size() > 0)
            burst[burst.size()-1].run_last = 1'b1;
        if (keep)
            foreach (burst[k])
                predicted_out.push_back(burst[k]);
    endtask

    // entered at a falling edge, returns at one
    task automatic wait_drained();
        src_valid <= 1'b0;
        while (predicted_out.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [sfr_pkg::CFG_IDX_W-1:0] idx, input logic [63:0] val);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        n_writes++;
        case (idx)
            sfr_pkg::REG_SEARCH_PATTERN:  find_pat = val;
            sfr_pkg::REG_SEARCH_LENGTH:
            begin
                find_len = val[3:0];
                win_cnt  = 0;
            end
            sfr_pkg::REG_REPLACE_PATTERN: subst_pat = val;
            sfr_pkg::REG_REPLACE_LENGTH:  subst_len = val[3:0];
            sfr_pkg::REG_REPLACE_MODE:    subst_mode = val[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // prediction runs at the falling edge after accept, never racing the checker
    task automatic push_request(input sfr_pkg::in_item_t it, input bit typed,
                                input sfr_pkg::out_item_t want);
        int gap;
        gap = (src_gap_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
        if (gap > 0)
        begin
            src_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        src_valid <= 1'b1;
        src_data  <= it;
        @(posedge clk);
        while (!src_ready)
            @(posedge clk);
        n_requests++;
        @(negedge clk);
        find_replace_step(it, !typed);
        if (typed)
            predicted_out.push_back(want);
    endtask

    function automatic void add_write(logic [sfr_pkg::CFG_IDX_W-1:0] idx, logic [63:0] val);
        dir_row_t r;
        r.kind  = ROW_WRITE;
        r.idx   = idx;
        r.val   = val;
        r.item  = '0;
        r.typed = 1'b0;
        r.want  = '0;
        dir_rows.push_back(r);
    endfunction

    function automatic void add_item(logic [7:0] b, logic e);
        dir_row_t r;
        r.kind  = ROW_ITEM;
        r.idx   = '0;
        r.val   = '0;
        r.item  = make_item(b, e);
        r.typed = 1'b0;
        r.want  = '0;
        dir_rows.push_back(r);
    endfunction

    function automatic void add_checked(logic [7:0] b, logic e, sfr_pkg::out_item_t want);
        dir_row_t r;
        r.kind  = ROW_ITEM;
        r.idx   = '0;
        r.val   = '0;
        r.item  = make_item(b, e);
        r.typed = 1'b1;
        r.want  = want;
        dir_rows.push_back(r);
    endfunction

    function automatic logic [63:0] draw_pattern();
        logic [63:0]    v;
        int             style;
        style = $urandom_range(0, 3);
        for (int i = 0; i < 8; i++)
        begin
            case (style)
                0:       v[8*i +: 8] = 8'h61 + 8'($urandom_range(0, 1));
                1:       v[8*i +: 8] = 8'($urandom_range(0, 255));
                2:       v[8*i +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                default: v[8*i +: 8] = 8'h61 + 8'($urandom_range(0, 3));
            endcase
        end
        return v;
    endfunction

    task automatic randomize_setup(input int ph);
        logic [63:0] v;
        n_setups++;
        if (ph < 2 || $urandom_range(0, 2) != 0)
            write_reg(sfr_pkg::REG_SEARCH_PATTERN, draw_pattern());
        if (ph < 2 || $urandom_range(0, 2) != 0)
            write_reg(sfr_pkg::REG_REPLACE_PATTERN, draw_pattern());
        v = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0:       v[3:0] = 4'd0;
            1:       v[3:0] = 4'd15;
            2:       v[3:0] = 4'd8;
            default: v[3:0] = 4'($urandom_range(1, 4));
        endcase
        if (ph == 0)
            v[3:0] = 4'd8;
        else if (ph == 1)
            v[3:0] = 4'd1;
        if (ph < 2 || $urandom_range(0, 1) != 0)
            write_reg(sfr_pkg::REG_SEARCH_LENGTH, v);
        v = {$urandom, $urandom};
        v[3:0] = ($urandom_range(0, 7) == 0) ? 4'd15 : 4'($urandom_range(0, 8));
        if (ph == 0)
            v[3:0] = 4'd8;
        else if (ph == 1)
            v[3:0] = 4'd0;
        if (ph < 2 || $urandom_range(0, 1) != 0)
            write_reg(sfr_pkg::REG_REPLACE_LENGTH, v);
        v = {$urandom, $urandom};
        if (ph < 2)
            v[0] = ph[0];
        write_reg(sfr_pkg::REG_REPLACE_MODE, v);
        if ($urandom_range(0, 3) == 0)
            write_reg(REG_FIRST_UNUSED + 3'($urandom_range(0, 2)), {$urandom, $urandom});
    endtask

    // strings are mostly built from pieces of the pattern so matches keep coming
    task automatic send_string(input int len, input bit noise, input bit closed);
        logic [7:0]     text [$];
        int             slen;
        int             run;
        slen = eff_find_len();
        while (text.size() < len)
        begin
            if (!noise && $urandom_range(0, 2) == 0)
            begin
                run = ($urandom_range(0, 3) == 0) ? $urandom_range(1, slen) : slen;
                for (int j = 0; j < run; j++)
                    text.push_back(find_pat[8*j +: 8]);
            end
            else if (!noise && $urandom_range(0, 1) == 0)
                text.push_back(find_pat[8*$urandom_range(0, slen - 1) +: 8]);
            else
                text.push_back(8'($urandom_range(0, 255)));
        end
        if (closed && !noise && $urandom_range(0, 2) == 0)
            for (int j = 0; j < slen; j++)
                text.push_back(find_pat[8*j +: 8]);
        foreach (text[k])
            push_request(make_item(text[k], closed && k == text.size() - 1), 1'b0, '0);
    endtask

    // result checker
    always @(posedge clk)
    begin
        sfr_pkg::out_item_t want;
        if (rst_n && dst_valid && dst_ready)
        begin
            n_results++;
            if (predicted_out.size() == 0)
            begin
                $error("result with nothing predicted: out_byte %0h has_byte %0b",
                       dst_data.out_byte, dst_data.has_byte);
                n_errors++;
            end
            else
            begin
                want = predicted_out.pop_front();
                if (dst_data.out_byte !== want.out_byte)
                begin
                    $error("out_byte: expected %0h, got %0h", want.out_byte, dst_data.out_byte);
                    n_errors++;
                end
                if (dst_data.has_byte !== want.has_byte)
                begin
                    $error("has_byte: expected %0b, got %0b", want.has_byte, dst_data.has_byte);
                    n_errors++;
                end
                if (dst_data.run_last !== want.run_last)
                begin
                    $error("run_last: expected %0b, got %0b", want.run_last, dst_data.run_last);
                    n_errors++;
                end
                if (dst_data.output_end !== want.output_end)
                begin
                    $error("output_end: expected %0b, got %0b",
                           want.output_end, dst_data.output_end);
                    n_errors++;
                end
            end
        end
    end

    // receiver: random stall bursts, plus one long hold-off when asked
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_asked != hold_served)
            begin
                hold_served++;
                dst_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else if (sink_stall_en && $urandom_range(0, 4) == 0)
            begin
                dst_ready <= 1'b0;
                repeat ($urandom_range(0, 3)) @(negedge clk);
            end
            else
                dst_ready <= 1'b1;
        end
    end

    initial
    begin
        int ph;
        int phase_start;
        int len;
        bit noise;

        for (int i = 0; i < sfr_pkg::MAX_PATTERN; i++)
            win[i] = 8'h00;

        // after reset: pattern 00, length 1, matches deleted
        add_checked(8'h00, 1'b1, result_of(8'h00, 1'b0, 1'b1, 1'b1));
        add_checked(8'hFF, 1'b1, result_of(8'hFF, 1'b1, 1'b1, 1'b1));
        add_write(REG_FIRST_UNUSED, '1);
        add_write(REG_LAST_UNUSED, 64'd1);
        add_checked(8'h00, 1'b1, result_of(8'h00, 1'b0, 1'b1, 1'b1));
        add_write(sfr_pkg::REG_SEARCH_PATTERN, 64'h0000_0000_0063_6261);
        add_write(sfr_pkg::REG_SEARCH_LENGTH, 64'd3);
        add_write(sfr_pkg::REG_REPLACE_PATTERN, 64'h0000_0000_0000_5958);
        add_write(sfr_pkg::REG_REPLACE_LENGTH, 64'd2);
        add_item("x", 1'b0);
        add_item("a", 1'b0);
        add_item("b", 1'b0);
        add_item("c", 1'b0);
        add_item("a", 1'b0);
        add_item("b", 1'b1);
        // empty replacement: whole string vanishes
        add_write(sfr_pkg::REG_REPLACE_LENGTH, 64'd0);
        add_item("a", 1'b0);
        add_item("b", 1'b0);
        add_checked("c", 1'b1, result_of(8'h00, 1'b0, 1'b1, 1'b1));
        // length 0 acts as 1, length 15 clamps to 8
        add_write(sfr_pkg::REG_SEARCH_LENGTH, 64'd0);
        add_write(sfr_pkg::REG_REPLACE_LENGTH, 64'd15);
        add_write(sfr_pkg::REG_REPLACE_PATTERN, '1);
        add_item("a", 1'b0);
        add_checked("q", 1'b1, result_of("q", 1'b1, 1'b1, 1'b1));
        add_write(sfr_pkg::REG_SEARCH_LENGTH, 64'd15);
        add_write(sfr_pkg::REG_SEARCH_PATTERN, '1);
        add_write(sfr_pkg::REG_REPLACE_PATTERN, 64'h0807_0605_0403_0201);
        add_write(sfr_pkg::REG_REPLACE_MODE, 64'd1);
        for (int i = 0; i < 7; i++)
            add_item(8'hFF, 1'b0);
        add_item(8'hFF, 1'b1);
        // end mode: inner match passes through, search length write drops the window
        add_write(sfr_pkg::REG_SEARCH_PATTERN, 64'h0000_0000_0000_6261);
        add_write(sfr_pkg::REG_SEARCH_LENGTH, 64'd2);
        add_item("a", 1'b0);
        add_item("b", 1'b0);
        add_item("a", 1'b0);
        add_write(sfr_pkg::REG_SEARCH_LENGTH, 64'd2);
        add_checked("c", 1'b1, result_of("c", 1'b1, 1'b1, 1'b1));

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[r])
        begin
            if (dir_rows[r].kind == ROW_WRITE)
                write_reg(dir_rows[r].idx, dir_rows[r].val);
            else
                push_request(dir_rows[r].item, dir_rows[r].typed, dir_rows[r].want);
        end
        n_directed = n_requests;

        ph = 0;
        while (n_requests - n_directed < RANDOM_ITEMS)
        begin
            randomize_setup(ph);
            if (n_requests - n_directed > RANDOM_ITEMS - 70)
            begin
                src_gap_en    = 1'b0;
                sink_stall_en <= 1'b0;
            end
            else
            begin
                src_gap_en    = ($urandom_range(0, 3) != 0);
                sink_stall_en <= ($urandom_range(0, 3) != 0);
            end
            if (ph == 2)
                hold_asked <= hold_asked + 1;
            phase_start = n_requests;
            while (n_requests - phase_start < PHASE_ITEMS)
            begin
                len   = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 24)
                                                     : $urandom_range(1, 12);
                noise = ($urandom_range(0, 9) == 0);
                send_string(len, noise, 1'b1);
            end
            // sometimes leave a string open across the next register writes
            if ($urandom_range(0, 1) != 0)
                send_string($urandom_range(1, 3), 1'b0, 1'b0);
            ph++;
        end

        wait_drained();
        $display("covered %0d requests (%0d directed), %0d results checked",
                 n_requests, n_directed, n_results);
        $display("%0d register writes over %0d random setups, one long output hold-off",
                 n_writes, n_setups);
        if (n_errors == 0 && predicted_out.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
